### hdl/stroke_stamp_interpolator_assert.svh
// Assertion macros used by the port-level checker file.
`ifndef STROKE_STAMP_INTERPOLATOR_ASSERT_SVH
`define STROKE_STAMP_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication under reset.
`define SSI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ssi assertion failed");

// Next-cycle implication under reset.
`define SSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ssi assertion failed");

`endif

### hdl/ssi_pkg.sv
// Shared constants, codes and control types of the stroke stamp interpolator.
package ssi_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = 8;
  localparam int MAX_STAMPS    = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int ROOT_BITS     = 25;
  localparam int DIV_NUM_BITS  = 42;
  localparam int DIV_DEN_BITS  = 25;
  localparam int DIV_CNT_BITS  = 6;
  localparam int K_BITS        = 7;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAMP_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAMP_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = 3'd4;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_BEGIN, OP_LOAD, OP_SQX, OP_SQY, OP_ROOT, OP_PMOD, OP_CNT,
    OP_TAKE, OP_MUL, OP_DIV, OP_STAMP, OP_NEXT, OP_FINISH, OP_DIRTY
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic busy;
    logic none_left;
    logic k_last;
  } dp_sts_t;

endpackage

### hdl/ssi_item_if.sv
// Pointer event channel.
interface ssi_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  modport source(output valid, action, pos_x, pos_y, input ready);
  modport sink(input valid, action, pos_x, pos_y, output ready);
endinterface

### hdl/ssi_rect_if.sv
// Rectangle result channel.
interface ssi_rect_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [15:0]        rect_w;
  logic [15:0]        rect_h;
  logic               is_dirty_rect;
  logic               last;
  modport source(output valid, rect_x, rect_y, rect_w, rect_h, is_dirty_rect, last,
                 input ready);
  modport sink(input valid, rect_x, rect_y, rect_w, rect_h, is_dirty_rect, last,
               output ready);
endinterface

### hdl/ssi_cfg_if.sv
// Register write channel.
interface ssi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/stroke_stamp_interpolator.sv
// Top level of the stroke stamp interpolator.
// One pointer event at a time. Begin, an ignored event, and end are accepted
// straight from idle; end then holds its dirty rectangle until taken. A move runs
// the squared length, the 25-step root and the 16- and 26-step spacing divisions,
// then, for each stamp, the 41-step quotient of the per-stamp position divide
// (both axes in parallel) and the wait for the output to be taken.
// A move emits at most 64 stamps. Register writes are taken on any cycle.
module stroke_stamp_interpolator (
  input logic        clk_i,
  input logic        rst_ni,
  ssi_item_if.sink   in_i,
  ssi_rect_if.source out_o,
  ssi_cfg_if.sink    cfg_i
);
  import ssi_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  ssi_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_action_i(in_i.action), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ssi_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_i.valid), .cfg_idx_i(cfg_i.index), .cfg_data_i(cfg_i.data),
    .pos_x_i(in_i.pos_x), .pos_y_i(in_i.pos_y),
    .rect_x_o(out_o.rect_x), .rect_y_o(out_o.rect_y),
    .rect_w_o(out_o.rect_w), .rect_h_o(out_o.rect_h),
    .dirty_o(out_o.is_dirty_rect), .last_o(out_o.last)
  );
endmodule

### hdl/ssi_div.sv
// Restoring divider, one quotient bit per cycle.
module ssi_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ssi_pkg::DIV_NUM_BITS-1:0]   num_i,
  input  logic [ssi_pkg::DIV_DEN_BITS-1:0]   den_i,
  input  logic [ssi_pkg::DIV_CNT_BITS-1:0]   steps_i,
  output logic                               busy_o,
  output logic [ssi_pkg::DIV_NUM_BITS-1:0]   quo_o,
  output logic [ssi_pkg::DIV_DEN_BITS-1:0]   rem_o
);
  import ssi_pkg::*;

  logic [DIV_NUM_BITS-1:0] num_q, quo_q;
  logic [DIV_DEN_BITS-1:0] den_q, rem_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [DIV_DEN_BITS:0]   shifted, diff;
  logic                    fits;

  assign shifted = {rem_q, num_q[DIV_NUM_BITS-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[DIV_NUM_BITS-2:0], 1'b0};
      quo_q <= {quo_q[DIV_NUM_BITS-2:0], fits};
      rem_q <= fits ? diff[DIV_DEN_BITS-1:0] : shifted[DIV_DEN_BITS-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

### hdl/ssi_dp.sv
// Datapath: registers, segment length root, dividers and stamp geometry.
module ssi_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ssi_pkg::dp_cmd_t                  cmd_i,
  output ssi_pkg::dp_sts_t                  sts_o,
  input  logic                              cfg_we_i,
  input  logic [ssi_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [ssi_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic signed [15:0]                pos_x_i,
  input  logic signed [15:0]                pos_y_i,
  output logic signed [15:0]                rect_x_o,
  output logic signed [15:0]                rect_y_o,
  output logic [15:0]                       rect_w_o,
  output logic [15:0]                       rect_h_o,
  output logic                              dirty_o,
  output logic                              last_o
);
  import ssi_pkg::*;

  // configuration
  logic [15:0] spacing_q;
  logic [6:0]  stamp_w_q, stamp_h_q;
  logic [13:0] canvas_w_q, canvas_h_q;

  // stroke state
  logic signed [15:0] anchor_x_q, anchor_y_q, px_q, py_q;
  logic signed [15:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic [15:0]        phase_q, phase_new_q, p_q, s_q;
  logic               active_q, any_q;

  // per move
  logic signed [16:0] dx_w, dy_w;
  logic [15:0]        mag_x_q, mag_y_q;
  logic               neg_x_q, neg_y_q;
  logic [33:0]        sq_q;
  logic [49:0]        rad_q;
  logic [27:0]        rrem_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [4:0]         rcnt_q;
  logic [K_BITS-1:0]  cnt_q, k_q;
  logic [ROOT_BITS-1:0] t_q;
  logic [40:0]        prod_x_q, prod_y_q;

  // root step
  logic [29:0] r_w, trial_w, rdiff_w;
  assign r_w     = {rrem_q, rad_q[49:48]};
  assign trial_w = {3'b0, root_q, 2'b01};
  assign rdiff_w = r_w - trial_w;

  // dividers
  logic                    dx_start, dy_start, dx_busy, dy_busy;
  logic [DIV_NUM_BITS-1:0] dx_num, dx_quo, dy_quo;
  logic [DIV_DEN_BITS-1:0] dx_den, dx_rem, dy_rem;
  logic [DIV_CNT_BITS-1:0] dx_steps;
  logic [25:0]             span_w;

  assign span_w = {1'b0, root_q} + {10'b0, dx_rem[15:0]};

  always_comb begin
    dx_start = 1'b0;
    dx_num   = {prod_x_q, 1'b0};
    dx_den   = root_q;
    dx_steps = 6'd41;
    case (cmd_i.op)
      OP_PMOD: begin
        dx_start = 1'b1;
        dx_num   = {phase_q, 26'b0};
        dx_den   = {9'b0, s_q};
        dx_steps = 6'd16;
      end
      OP_CNT: begin
        dx_start = 1'b1;
        dx_num   = {span_w, 16'b0};
        dx_den   = {9'b0, s_q};
        dx_steps = 6'd26;
      end
      OP_DIV: begin
        dx_start = 1'b1;
      end
      default: begin
      end
    endcase
  end
  assign dy_start = cmd_i.op == OP_DIV;

  ssi_div u_div_x (
    .clk_i, .rst_ni, .start_i(dx_start), .num_i(dx_num), .den_i(dx_den),
    .steps_i(dx_steps), .busy_o(dx_busy), .quo_o(dx_quo), .rem_o(dx_rem)
  );
  ssi_div u_div_y (
    .clk_i, .rst_ni, .start_i(dy_start), .num_i({prod_y_q, 1'b0}), .den_i(root_q),
    .steps_i(6'd41), .busy_o(dy_busy), .quo_o(dy_quo), .rem_o(dy_rem)
  );

  // truncate toward zero after the exact quotient
  function automatic logic signed [17:0] interp(logic signed [15:0] a, logic neg,
                                                logic [16:0] q, logic rem_nz);
    logic signed [17:0] v;
    v = 18'(a);
    if (!neg) begin
      v = v + $signed({1'b0, q});
      if (v[17] && rem_nz) v = v + 18'sd1;
    end else begin
      v = v - $signed({1'b0, q});
      if (!v[17] && v != '0 && rem_nz) v = v - 18'sd1;
    end
    return v;
  endfunction

  logic signed [17:0] cx18, cy18;
  logic signed [15:0] cx, cy;
  assign cx18 = interp(anchor_x_q, neg_x_q, dx_quo[16:0], dx_rem != '0);
  assign cy18 = interp(anchor_y_q, neg_y_q, dy_quo[16:0], dy_rem != '0);
  assign cx   = cx18[15:0];
  assign cy   = cy18[15:0];

  // dirty rectangle
  logic signed [17:0] drx, dry, drw, drh;
  assign drx = 18'(min_x_q) - $signed({12'b0, stamp_w_q[6:1]});
  assign dry = 18'(min_y_q) - $signed({12'b0, stamp_h_q[6:1]});
  assign drw = 18'(max_x_q) - 18'(min_x_q) + $signed({11'b0, stamp_w_q});
  assign drh = 18'(max_y_q) - 18'(min_y_q) + $signed({11'b0, stamp_h_q});

  assign dx_w = 17'(pos_x_i) - 17'(anchor_x_q);
  assign dy_w = 17'(pos_y_i) - 17'(anchor_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q  <= 16'd512;
      stamp_w_q  <= 7'd4;
      stamp_h_q  <= 7'd4;
      canvas_w_q <= 14'd1024;
      canvas_h_q <= 14'd1024;
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      phase_q    <= '0;
      min_x_q    <= 16'sh7fff;
      min_y_q    <= 16'sh7fff;
      max_x_q    <= 16'sh8000;
      max_y_q    <= 16'sh8000;
      active_q   <= 1'b0;
      any_q      <= 1'b0;
      rcnt_q     <= '0;
      cnt_q      <= '0;
      k_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SPACING:       spacing_q  <= cfg_data_i;
          REG_STAMP_WIDTH:   stamp_w_q  <= cfg_data_i[6:0];
          REG_STAMP_HEIGHT:  stamp_h_q  <= cfg_data_i[6:0];
          REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i[13:0];
          REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i[13:0];
          default: begin
          end
        endcase
      end
      if (rcnt_q != '0) rcnt_q <= rcnt_q - 1'b1;
      case (cmd_i.op)
        OP_BEGIN: begin
          active_q   <= !active_q;
          anchor_x_q <= pos_x_i;
          anchor_y_q <= pos_y_i;
          min_x_q    <= 16'sh7fff;
          min_y_q    <= 16'sh7fff;
          max_x_q    <= 16'sh8000;
          max_y_q    <= 16'sh8000;
          any_q      <= 1'b0;
        end
        OP_ROOT: rcnt_q <= 5'd25;
        OP_TAKE: begin
          cnt_q <= (dx_quo > DIV_NUM_BITS'(MAX_STAMPS)) ? K_BITS'(MAX_STAMPS)
                                                        : dx_quo[K_BITS-1:0];
          k_q   <= K_BITS'(1);
        end
        OP_STAMP: begin
          if (cx < min_x_q) min_x_q <= cx;
          if (cx > max_x_q) max_x_q <= cx;
          if (cy < min_y_q) min_y_q <= cy;
          if (cy > max_y_q) max_y_q <= cy;
          any_q <= 1'b1;
        end
        OP_NEXT: k_q <= k_q + 1'b1;
        OP_FINISH: begin
          anchor_x_q <= px_q;
          anchor_y_q <= py_q;
          phase_q    <= phase_new_q;
        end
        OP_DIRTY: active_q <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rcnt_q != '0) begin
      rad_q <= {rad_q[47:0], 2'b00};
      if (r_w >= trial_w) begin
        rrem_q <= rdiff_w[27:0];
        root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rrem_q <= r_w[27:0];
        root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
    case (cmd_i.op)
      OP_LOAD: begin
        px_q    <= pos_x_i;
        py_q    <= pos_y_i;
        mag_x_q <= dx_w[16] ? 16'(-dx_w) : dx_w[15:0];
        mag_y_q <= dy_w[16] ? 16'(-dy_w) : dy_w[15:0];
        neg_x_q <= dx_w[16];
        neg_y_q <= dy_w[16];
        s_q     <= (spacing_q == '0) ? 16'd1 : spacing_q;
      end
      OP_SQX: sq_q <= {2'b0, 32'(mag_x_q) * 32'(mag_x_q)};
      OP_SQY: sq_q <= sq_q + {2'b0, 32'(mag_y_q) * 32'(mag_y_q)};
      OP_ROOT: begin
        rad_q  <= {sq_q, 16'b0};
        rrem_q <= '0;
        root_q <= '0;
      end
      OP_CNT: p_q <= dx_rem[15:0];
      OP_TAKE: begin
        phase_new_q <= dx_rem[15:0];
        t_q         <= {9'b0, s_q - p_q};
      end
      OP_MUL: begin
        prod_x_q <= t_q * mag_x_q;
        prod_y_q <= t_q * mag_y_q;
      end
      OP_STAMP: begin
        rect_x_o <= cx - $signed({10'b0, stamp_w_q[6:1]});
        rect_y_o <= cy - $signed({10'b0, stamp_h_q[6:1]});
        rect_w_o <= {9'b0, stamp_w_q};
        rect_h_o <= {9'b0, stamp_h_q};
        dirty_o  <= 1'b0;
        last_o   <= k_q == cnt_q;
      end
      OP_NEXT: t_q <= t_q + {9'b0, s_q};
      OP_DIRTY: begin
        dirty_o <= 1'b1;
        last_o  <= 1'b1;
        if (any_q) begin
          rect_x_o <= drx[17] ? 16'sd0 : drx[15:0];
          rect_y_o <= dry[17] ? 16'sd0 : dry[15:0];
          rect_w_o <= (drw > $signed({4'b0, canvas_w_q})) ? {2'b0, canvas_w_q} : drw[15:0];
          rect_h_o <= (drh > $signed({4'b0, canvas_h_q})) ? {2'b0, canvas_h_q} : drh[15:0];
        end else begin
          rect_x_o <= '0;
          rect_y_o <= '0;
          rect_w_o <= '0;
          rect_h_o <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.active    = active_q;
  assign sts_o.busy      = (rcnt_q != '0) || dx_busy || dy_busy;
  assign sts_o.none_left = cnt_q == '0;
  assign sts_o.k_last    = k_q == cnt_q;
endmodule

### hdl/ssi_ctrl.sv
// Controller: sequences each pointer event through the datapath.
module ssi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_action_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ssi_pkg::dp_sts_t sts_i,
  output ssi_pkg::dp_cmd_t cmd_o
);
  import ssi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_RSTRT = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_PMOD  = 4'd5;
  localparam logic [3:0] S_CNT   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DSTRT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_DOUT  = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_BEGIN) begin
            cmd_o.op = OP_BEGIN;
          end else if (sts_i.active && in_action_i == ACT_MOVE) begin
            cmd_o.op = OP_LOAD;
            state_d  = S_SQX;
          end else if (sts_i.active && in_action_i == ACT_END) begin
            cmd_o.op = OP_DIRTY;
            state_d  = S_DOUT;
          end
        end
      end
      S_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = S_RSTRT;
      end
      S_RSTRT: begin
        cmd_o.op = OP_ROOT;
        state_d  = S_ROOT;
      end
      S_ROOT: if (!sts_i.busy) begin
        cmd_o.op = OP_PMOD;
        state_d  = S_PMOD;
      end
      S_PMOD: if (!sts_i.busy) begin
        cmd_o.op = OP_CNT;
        state_d  = S_CNT;
      end
      S_CNT: if (!sts_i.busy) begin
        cmd_o.op = OP_TAKE;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (sts_i.none_left) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_DSTRT;
      end
      S_DSTRT: begin
        cmd_o.op = OP_DIV;
        state_d  = S_DIV;
      end
      S_DIV: if (!sts_i.busy) begin
        cmd_o.op = OP_STAMP;
        state_d  = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          // advance to the next stamp or close the move
          if (sts_i.k_last) begin
            cmd_o.op = OP_FINISH;
            state_d  = S_IDLE;
          end else begin
            cmd_o.op = OP_NEXT;
            state_d  = S_MUL;
          end
        end
      end
      S_DOUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### hdl/ssi_checker.sv
// Port-level checker for the stroke stamp interpolator and its bind.
`include "stroke_stamp_interpolator_assert.svh"

module ssi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_dirty_i,
  input logic        out_last_i,
  input logic [15:0] out_rect_x_i
);
  // a stalled result stays offered
  `SSI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // one event at a time: no intake while a result is offered
  `SSI_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i)
  // the dirty rectangle always closes its event
  `SSI_ASSERT_NOW(a_dirty_last, clk_i, rst_ni, out_valid_i && out_dirty_i, out_last_i)
  // the dirty rectangle is clipped at zero
  `SSI_ASSERT_NOW(a_dirty_clip, clk_i, rst_ni, out_valid_i && out_dirty_i, !out_rect_x_i[15])
endmodule

bind stroke_stamp_interpolator ssi_checker u_ssi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .out_dirty_i(out_o.is_dirty_rect), .out_last_i(out_o.last),
  .out_rect_x_i(out_o.rect_x)
);

### test/ssi_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side helpers for the stroke stamp interpolator channels.
package ssi_tb_pkg;
  import ssi_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic               dirty;
    logic               last;
  } rect_t;

  typedef struct {
    logic [1:0]         action;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } event_t;
endpackage

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stroke stamp interpolator: directed and random
// pointer events, predicted rectangles compared in order.
module tb;
  import ssi_pkg::*;
  import ssi_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ssi_item_if in_if ();
  ssi_rect_if out_if ();
  ssi_cfg_if cfg_if ();

  stroke_stamp_interpolator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .cfg_i(cfg_if.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned spacing_q, sw_q, sh_q, cw_q, ch_q, phase_q;
  longint anc_x, anc_y, bmin_x, bmax_x, bmin_y, bmax_y;
  bit active_q, any_q;
  rect_t rect_fifo[$];
  int errors = 0;
  bit stall_mode = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void box_reset();
    bmin_x = 32767; bmin_y = 32767; bmax_x = -32768; bmax_y = -32768; any_q = 0;
  endfunction

  function automatic longint unsigned isqrt_q8(longint unsigned s);
    logic [127:0] v, r, root, trial;
    v = 128'(s) << 16;
    r = 0; root = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 2) | ((v >> (2 * i)) & 3);
      trial = (root << 2) | 1;
      if (r >= trial) begin
        r = r - trial; root = (root << 1) | 1;
      end else root = root << 1;
    end
    return longint'(root);
  endfunction

  function automatic longint lerp_axis(longint a, longint d, longint unsigned t,
                                       longint unsigned len);
    logic [127:0] prod;
    longint unsigned mag, q, rm;
    longint v;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    prod = 128'(t) * 128'(mag);
    q = longint'(prod / len);
    rm = longint'(prod % len);
    if (d >= 0) begin
      v = a + longint'(q);
      return (v < 0 && rm != 0) ? v + 1 : v;
    end
    v = a - longint'(q);
    return (v > 0 && rm != 0) ? v - 1 : v;
  endfunction

  function automatic void push_rect(longint x, longint y, longint w, longint h, bit d);
    rect_t r;
    r.x = x[15:0]; r.y = y[15:0]; r.w = w[15:0]; r.h = h[15:0];
    r.dirty = d; r.last = 0;
    rect_fifo.push_back(r);
  endfunction

  function automatic int predict_event(event_t e);
    longint unsigned s, sq, len, p, cnt, t;
    longint dx, dy, cx, cy, rx, ry, rw, rh;
    int n;
    n = 0;
    if (e.action == ACT_BEGIN) begin
      active_q = !active_q; anc_x = e.px; anc_y = e.py; box_reset();
      return 0;
    end
    if (!active_q || e.action == 2'd3) return 0;
    if (e.action == ACT_MOVE) begin
      s = (spacing_q == 0) ? 1 : spacing_q;
      dx = e.px - anc_x; dy = e.py - anc_y;
      sq = dx * dx + dy * dy;
      len = isqrt_q8(sq);
      p = phase_q % s;
      cnt = (len + p) / s;
      if (cnt > MAX_STAMPS) cnt = MAX_STAMPS;
      for (longint unsigned k = 1; k <= cnt && len != 0; k++) begin
        t = k * s - p;
        cx = lerp_axis(anc_x, dx, t, len);
        cy = lerp_axis(anc_y, dy, t, len);
        if (cx < bmin_x) bmin_x = cx;
        if (cx > bmax_x) bmax_x = cx;
        if (cy < bmin_y) bmin_y = cy;
        if (cy > bmax_y) bmax_y = cy;
        any_q = 1;
        push_rect(cx - longint'(sw_q / 2), cy - longint'(sh_q / 2), sw_q, sh_q, 0);
        n++;
      end
      phase_q = ((p + len) % s) & 16'hffff;
      anc_x = e.px; anc_y = e.py;
    end else begin
      rx = 0; ry = 0; rw = 0; rh = 0;
      if (any_q) begin
        rx = bmin_x - longint'(sw_q / 2);
        ry = bmin_y - longint'(sh_q / 2);
        rw = bmax_x - bmin_x + longint'(sw_q);
        rh = bmax_y - bmin_y + longint'(sh_q);
        if (rx < 0) rx = 0;
        if (ry < 0) ry = 0;
        if (rw > longint'(cw_q)) rw = cw_q;
        if (rh > longint'(ch_q)) rh = ch_q;
      end
      push_rect(rx, ry, rw, rh, 1);
      n = 1;
      active_q = 0;
    end
    if (n > 0) rect_fifo[$].last = 1;
    return n;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val[15:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_SPACING: spacing_q = val & 16'hffff;
      REG_STAMP_WIDTH: sw_q = val & 7'h7f;
      REG_STAMP_HEIGHT: sh_q = val & 7'h7f;
      REG_CANVAS_WIDTH: cw_q = val & 14'h3fff;
      REG_CANVAS_HEIGHT: ch_q = val & 14'h3fff;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(input longint unsigned sp, sw, sh, cw, ch);
    write_reg(REG_SPACING, sp);
    write_reg(REG_STAMP_WIDTH, sw);
    write_reg(REG_STAMP_HEIGHT, sh);
    write_reg(REG_CANVAS_WIDTH, cw);
    write_reg(REG_CANVAS_HEIGHT, ch);
  endtask

  // drive one event; the caller is at a falling edge
  task automatic send_event(input event_t e);
    void'(predict_event(e));
    in_if.valid <= 1'b1;
    in_if.action <= e.action;
    in_if.pos_x <= e.px;
    in_if.pos_y <= e.py;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (rect_fifo.size() != 0) @(negedge clk_i);
    // a trailing begin or ignored event may still be in flight
    repeat (200) @(negedge clk_i);
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else if (!stall_mode) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    rect_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rect_fifo.size() == 0) report("rectangle with none expected");
      else begin
        exp_r = rect_fifo.pop_front();
        if (out_if.rect_x !== exp_r.x)
          report($sformatf("rect_x %0d exp %0d", out_if.rect_x, exp_r.x));
        if (out_if.rect_y !== exp_r.y)
          report($sformatf("rect_y %0d exp %0d", out_if.rect_y, exp_r.y));
        if (out_if.rect_w !== exp_r.w)
          report($sformatf("rect_w %0d exp %0d", out_if.rect_w, exp_r.w));
        if (out_if.rect_h !== exp_r.h)
          report($sformatf("rect_h %0d exp %0d", out_if.rect_h, exp_r.h));
        if (out_if.is_dirty_rect !== exp_r.dirty)
          report($sformatf("is_dirty_rect %0b exp %0b", out_if.is_dirty_rect, exp_r.dirty));
        if (out_if.last !== exp_r.last)
          report($sformatf("last %0b exp %0b", out_if.last, exp_r.last));
      end
    end
  end

  // directed table: action, x, y
  event_t dir_tab[$];

  function automatic event_t mk(input logic [1:0] a, input int x, input int y);
    event_t e;
    e.action = a; e.px = x[15:0]; e.py = y[15:0];
    return e;
  endfunction

  function automatic event_t rand_move(input longint x, input longint y, input int reach);
    return mk(ACT_MOVE, int'(x) + $urandom_range(0, 2 * reach) - reach,
              int'(y) + $urandom_range(0, 2 * reach) - reach);
  endfunction

  initial begin
    event_t e;
    int burst, sent, reach;
    in_if.valid = 1'b0; in_if.action = ACT_BEGIN; in_if.pos_x = 0; in_if.pos_y = 0;
    cfg_if.valid = 1'b0; cfg_if.index = REG_SPACING; cfg_if.data = 0;
    out_if.ready = 1'b0;
    spacing_q = 512; sw_q = 4; sh_q = 4; cw_q = 1024; ch_q = 1024;
    anc_x = 0; anc_y = 0; phase_q = 0; active_q = 0; box_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: ignored events, empty end, short strokes, extremes
    dir_tab = '{mk(ACT_MOVE, 5, 5), mk(ACT_END, 0, 0), mk(2'd3, 1, 1),
                mk(ACT_BEGIN, 0, 0), mk(ACT_END, 9, 9),
                mk(ACT_BEGIN, 10, 10), mk(ACT_MOVE, 10, 10), mk(ACT_MOVE, 20, 10),
                mk(2'd3, -1, -1), mk(ACT_MOVE, 20, 30), mk(ACT_END, 0, 0),
                mk(ACT_BEGIN, 1, 1), mk(ACT_MOVE, -8, -3), mk(ACT_BEGIN, 0, 0),
                mk(ACT_BEGIN, -32768, -32768), mk(ACT_MOVE, 32767, 32767),
                mk(ACT_MOVE, -32768, 32767), mk(ACT_END, 0, 0),
                mk(ACT_BEGIN, 32767, -32768), mk(ACT_MOVE, 32700, -32700),
                mk(ACT_END, 0, 0)};
    stall_mode = 0;
    foreach (dir_tab[i]) send_event(dir_tab[i]);
    drain();

    // extreme spacing values with small and large stamp and canvas sizes
    configure(0, 64, 1, 1, 1);
    foreach (dir_tab[i]) send_event(dir_tab[i]);
    drain();
    configure(65535, 1, 64, 8192, 8192);
    foreach (dir_tab[i]) send_event(dir_tab[i]);
    drain();

    // random: strokes with random content, some noise
    sent = 0;
    for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
      configure($urandom_range(1, 3) == 1 ? $urandom_range(0, 65535) : $urandom_range(64, 2048),
                $urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 8192), $urandom_range(1, 8192));
      stall_mode = phase_idx[0];
      while (sent < 48 * (phase_idx + 1)) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst; b++) begin
          reach = ($urandom_range(0, 9) == 0) ? 32767 : 40;
          case ($urandom_range(0, 9))
            0: e = mk(ACT_BEGIN, $urandom_range(0, 65535), $urandom_range(0, 65535));
            1: e = mk(ACT_END, $urandom_range(0, 65535), $urandom_range(0, 65535));
            2: e = mk(2'd3, $urandom_range(0, 65535), $urandom_range(0, 65535));
            default: begin
              if (!active_q) e = mk(ACT_BEGIN, $urandom_range(0, 65535) - 32768,
                                    $urandom_range(0, 65535) - 32768);
              else e = rand_move(anc_x, anc_y, reach);
            end
          endcase
          send_event(e);
          sent++;
        end
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      if (active_q) send_event(mk(ACT_END, 0, 0));
      drain();
    end

    if (errors == 0) $display("stroke_stamp_interpolator regression: pass");
    else $display("stroke_stamp_interpolator regression: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("stroke_stamp_interpolator regression: fail");
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/ssi_pkg.sv
hdl/ssi_item_if.sv
hdl/ssi_rect_if.sv
hdl/ssi_cfg_if.sv
hdl/ssi_div.sv
hdl/ssi_dp.sv
hdl/ssi_ctrl.sv
hdl/stroke_stamp_interpolator.sv
hdl/ssi_checker.sv
test/ssi_tb_if.sv
test/tb.sv
